// ===== sv/mcbt_pkg.sv =====
// Shared constants, types and helpers for the multi-channel blink timer.
package mcbt_pkg;

   localparam int CHANNEL_COUNT = 4;
   localparam int TIME_BITS     = 8;

   // Channels that have an enable bit and a times register.
   localparam int REG_CHANNELS  = (CHANNEL_COUNT < 4) ? CHANNEL_COUNT : 4;
   localparam int MASK_BITS     = 4;

   localparam int REQ_TYPE_BITS = 3;
   localparam int CHAN_BITS     = 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [REQ_TYPE_BITS-1:0] REQ_TICK         = 3'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_SET_STATE    = 3'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_REQUIRE      = 3'd2;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_UNREQUIRE    = 3'd3;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_RESET_ALL    = 3'd4;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_STOP_ALL     = 3'd5;

   localparam logic [CSR_IDX_BITS-1:0]  CSR_ENABLE_MASK  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0]  CSR_CHAN0_TIMES  = 3'd1;

   typedef logic [TIME_BITS-1:0] time_type;

   typedef struct packed {
      logic tick;
      logic set_state;
      logic set_value;
      logic require;
      logic unrequire;
      logic reset_all;
      logic stop_all;
   } chan_cmd_type;

   // Low byte is the visible length, high byte the invisible one.
   function automatic time_type phase_len(input logic [15:0] times, input logic vis);
      logic [15:0] wide;
      wide = {8'd0, (vis ? times[7:0] : times[15:8])};
      return wide[TIME_BITS-1:0];
   endfunction

endpackage

// ===== sv/mcbt_req_if.sv =====
// Request channel interface for the blink timer.
interface mcbt_req_if;
   logic                                valid;
   logic                                ready;
   logic [mcbt_pkg::REQ_TYPE_BITS-1:0]  req_type;
   logic [mcbt_pkg::CHAN_BITS-1:0]      channel;
   logic                                visible_value;

   modport source (output valid, output req_type, output channel, output visible_value,
                   input ready);
   modport sink   (input valid, input req_type, input channel, input visible_value,
                   output ready);
endinterface

// ===== sv/mcbt_rsp_if.sv =====
// Result channel interface for the blink timer.
interface mcbt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mcbt_pkg::MASK_BITS-1:0]  visible_mask;
   logic                            update_request;
   logic [mcbt_pkg::MASK_BITS-1:0]  running_mask;

   modport source (output valid, output visible_mask, output update_request,
                   output running_mask, input ready);
   modport sink   (input valid, input visible_mask, input update_request,
                   input running_mask, output ready);
endinterface

// ===== sv/mcbt_chan.sv =====
// One blink channel: phase, required and running flags, and the countdown.
module mcbt_chan (
   input  logic                   clock,
   input  logic                   reset,
   input  mcbt_pkg::chan_cmd_type cmd,
   input  logic                   enabled,
   input  logic [15:0]            times,
   output logic                   phase_next,
   output logic                   running_next,
   output logic                   update
);

   logic                phase_ff, phase_in;
   logic                required_ff, required_in;
   logic                running_ff, running_in;
   mcbt_pkg::time_type  remain_ff, remain_in;

   always_comb begin
      phase_in    = phase_ff;
      required_in = required_ff;
      running_in  = running_ff;
      remain_in   = remain_ff;
      update      = 1'b0;

      if (cmd.tick && running_ff) begin
         // a count of 0 or 1 expires on this tick
         if (remain_ff <= mcbt_pkg::time_type'(1)) begin
            phase_in  = !phase_ff;
            remain_in = mcbt_pkg::phase_len(times, !phase_ff);
            update    = 1'b1;
         end else begin
            remain_in = remain_ff - mcbt_pkg::time_type'(1);
         end
      end

      if (cmd.set_state) begin
         phase_in = cmd.set_value;
         if (running_ff) begin
            remain_in = mcbt_pkg::phase_len(times, cmd.set_value);
            update    = (cmd.set_value != phase_ff);
         end
      end

      if (cmd.require)
         required_in = 1'b1;
      if (cmd.unrequire)
         required_in = 1'b0;

      if (cmd.reset_all) begin
         if (!(enabled && required_ff)) begin
            running_in = 1'b0;
         end else if (!running_ff) begin
            running_in = 1'b1;
            remain_in  = mcbt_pkg::phase_len(times, phase_ff);
         end
      end

      if (cmd.stop_all)
         running_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= 1'b0;
         required_ff <= 1'b0;
         running_ff  <= 1'b0;
         remain_ff   <= '0;
      end else begin
         phase_ff    <= phase_in;
         required_ff <= required_in;
         running_ff  <= running_in;
         remain_ff   <= remain_in;
      end
   end

   assign phase_next   = phase_in;
   assign running_next = running_in;

endmodule

// ===== sv/multi_channel_blink_timer_top.sv =====
// Top level of the multi-channel blink timer: request register, channels, result register.
//
//   port   direction  handshake    contents
//   req    in         valid/ready  req_type, channel, visible_value
//   rsp    out        valid/ready  visible_mask, update_request, running_mask
//   csr_*  in         write enable enable_mask, chan0..3_times
//
// One item per cycle while rsp is not stalled; an accepted item passes through the
// request register, then through the channel update into the result register.
// req.ready drops only while both the request register and the result
// register are full and rsp is stalled.
// Synchronous active-high reset clears all channel state, the configuration registers and the valid flags.
module multi_channel_blink_timer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   mcbt_req_if.sink                             req,
   mcbt_rsp_if.source                           rsp,
   input  logic                                 csr_we,
   input  logic [mcbt_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [mcbt_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   // configuration
   logic [mcbt_pkg::MASK_BITS-1:0] enable_ff;
   logic [15:0]                    times_ff [mcbt_pkg::REG_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
      end else if (csr_we && csr_index == mcbt_pkg::CSR_ENABLE_MASK) begin
         enable_ff <= csr_wdata[mcbt_pkg::MASK_BITS-1:0];
      end
   end

   for (genvar c = 0; c < mcbt_pkg::REG_CHANNELS; c++) begin : g_times
      always_ff @(posedge clock) begin
         if (reset) begin
            times_ff[c] <= '0;
         end else if (csr_we &&
                      csr_index == mcbt_pkg::CSR_CHAN0_TIMES
                                   + mcbt_pkg::CSR_IDX_BITS'(c)) begin
            times_ff[c] <= csr_wdata;
         end
      end
   end

   // request register
   logic                                s1_valid_ff;
   logic [mcbt_pkg::REQ_TYPE_BITS-1:0]  s1_type_ff;
   logic [mcbt_pkg::CHAN_BITS-1:0]      s1_chan_ff;
   logic                                s1_vis_ff;
   logic                                rsp_valid_ff;
   logic                                stall;
   logic                                go;

   assign stall     = rsp_valid_ff && !rsp.ready;
   assign go        = s1_valid_ff && !stall;
   assign req.ready = !(s1_valid_ff && stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_type_ff <= req.req_type;
         s1_chan_ff <= req.channel;
         s1_vis_ff  <= req.visible_value;
      end
   end

   // channels
   logic [mcbt_pkg::CHANNEL_COUNT-1:0] phase_next;
   logic [mcbt_pkg::CHANNEL_COUNT-1:0] running_next;
   logic [mcbt_pkg::CHANNEL_COUNT-1:0] chan_update;
   logic [mcbt_pkg::CHANNEL_COUNT-1:0] chan_enabled;

   for (genvar c = 0; c < mcbt_pkg::CHANNEL_COUNT; c++) begin : g_chan
      mcbt_pkg::chan_cmd_type cmd;
      logic                   addressed;
      logic [15:0]            times;

      if (c < 4) begin : g_reg
         assign addressed       = (s1_chan_ff == mcbt_pkg::CHAN_BITS'(c));
         assign chan_enabled[c] = enable_ff[c];
         assign times           = times_ff[c];
      end else begin : g_noreg
         // channels past four: no enable, zero lengths, not addressable
         assign addressed       = 1'b0;
         assign chan_enabled[c] = 1'b0;
         assign times           = '0;
      end

      assign cmd.tick      = go && s1_type_ff == mcbt_pkg::REQ_TICK;
      assign cmd.set_state = go && s1_type_ff == mcbt_pkg::REQ_SET_STATE && addressed;
      assign cmd.set_value = s1_vis_ff;
      assign cmd.require   = go && s1_type_ff == mcbt_pkg::REQ_REQUIRE && addressed;
      assign cmd.unrequire = go && s1_type_ff == mcbt_pkg::REQ_UNREQUIRE;
      assign cmd.reset_all = go && s1_type_ff == mcbt_pkg::REQ_RESET_ALL;
      assign cmd.stop_all  = go && s1_type_ff == mcbt_pkg::REQ_STOP_ALL;

      mcbt_chan u_chan (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .enabled      (chan_enabled[c]),
         .times        (times),
         .phase_next   (phase_next[c]),
         .running_next (running_next[c]),
         .update       (chan_update[c])
      );
   end

   // result masks cover the first four channels
   logic [mcbt_pkg::MASK_BITS-1:0] vis_mask_in;
   logic [mcbt_pkg::MASK_BITS-1:0] run_mask_in;

   for (genvar b = 0; b < mcbt_pkg::MASK_BITS; b++) begin : g_mask
      if (b < mcbt_pkg::CHANNEL_COUNT) begin : g_used
         assign vis_mask_in[b] = !chan_enabled[b] || phase_next[b];
         assign run_mask_in[b] = running_next[b];
      end else begin : g_unused
         assign vis_mask_in[b] = 1'b0;
         assign run_mask_in[b] = 1'b0;
      end
   end

   // result register
   logic [mcbt_pkg::MASK_BITS-1:0] rsp_vis_ff;
   logic                           rsp_upd_ff;
   logic [mcbt_pkg::MASK_BITS-1:0] rsp_run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!stall) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_vis_ff <= vis_mask_in;
         rsp_upd_ff <= |chan_update;
         rsp_run_ff <= run_mask_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.visible_mask   = rsp_vis_ff;
   assign rsp.update_request = rsp_upd_ff;
   assign rsp.running_mask   = rsp_run_ff;

endmodule
